### rtl/core/buc_pkg.sv
// Shared types and codes for the bounded unsorted list core.
package buc_pkg;

    // Operation codes
    typedef enum logic [2:0] {
        OP_INSERT    = 3'd0,
        OP_DELETE    = 3'd1,
        OP_LOOKUP    = 3'd2,
        OP_RST_CUR   = 3'd3,
        OP_READ_NEXT = 3'd4
    } op_t;

    // Result status codes
    typedef enum logic [1:0] {
        ST_OK       = 2'd0,
        ST_FULL     = 2'd1,
        ST_NOTFOUND = 2'd2,
        ST_NO_NEXT  = 2'd3
    } status_t;

    // Control sequencer states
    typedef enum logic {
        S_IDLE   = 1'b0,
        S_COMMIT = 1'b1
    } state_t;

    // Commands broadcast to every cell
    typedef struct packed {
        logic match_en;  // capture compare and cursor read for the new word
        logic ins_en;    // append at the tail
        logic del_en;    // close the gap at the first match
    } cell_cmd_t;

    // Per-cell status returned to the controller
    typedef struct packed {
        logic match;       // entry is valid and equals the word value
        logic before_cur;  // first match sits below the cursor
    } cell_stat_t;

endpackage

### rtl/core/buc_cell.sv
// One storage cell of the list chain: entry, match flag and cursor tap.
module buc_cell #(
    parameter int EW       = 32,
    parameter int CW       = 7,
    parameter int CELL_IDX = 0
) (
    input  logic              clk,
    input  buc_pkg::cell_cmd_t cmd,
    input  logic [EW-1:0]     cmp_value,
    input  logic [CW-1:0]     count,
    input  logic [CW-1:0]     cursor,
    input  logic [EW-1:0]     right_data,
    input  logic              prefix_in,
    output logic              prefix_out,
    output logic [EW-1:0]     data_out,
    output logic [EW-1:0]     rd_out,
    output buc_pkg::cell_stat_t stat
);

    localparam logic [CW-1:0] MyIdx = CW'(CELL_IDX);

    logic [EW-1:0] data_reg;
    logic [EW-1:0] rd_reg;
    logic          match_reg;
    logic          is_valid;
    logic          is_tail;
    logic          first;

    assign is_valid = (MyIdx < count);
    assign is_tail  = (MyIdx == count);

    // Match and cursor tap are captured with the word; entry updates on commit
    always_ff @(posedge clk)
    begin
        if (cmd.match_en)
        begin
            match_reg <= is_valid && (data_reg == cmp_value);
            rd_reg    <= (MyIdx == cursor) ? data_reg : '0;
        end
        if (cmd.ins_en && is_tail)
        begin
            data_reg <= cmp_value;
        end
        else if (cmd.del_en && prefix_out)
        begin
            data_reg <= right_data;
        end
    end

    // Prefix chain marks every cell at or past the first match
    assign prefix_out      = prefix_in | match_reg;
    assign first           = match_reg & ~prefix_in;
    assign data_out        = data_reg;
    assign rd_out          = rd_reg;
    assign stat.match      = match_reg;
    assign stat.before_cur = first && (MyIdx < cursor);

endmodule

### rtl/core/bounded_unsorted_list_core.sv
// Top level of the bounded unsorted list: controller and chain of cells.
//
// Usage:
//   Input channel (in_valid / in_ready) carries one word: an operation code
//   and a value. Operations are insert at tail, delete first match, lookup,
//   reset cursor and read next. Output channel (out_valid / out_ready)
//   returns one result word per input word: status, found, item_out,
//   has_next, entry_count, is_empty and is_full.
// Sequence:
//   An accepted word has its compare and cursor tap captured in every cell;
//   in the commit state the update and the result are registered together,
//   and out_valid rises with the result. A new word is not accepted while
//   the previous one still waits to commit.
// Stall:
//   A new word is accepted while the previous result still waits; its
//   commit holds until the output register is free, and in_ready stays low
//   until then.
// Reset:
//   rst_n clears the count, the cursor and the control state; the cursor
//   starts ended. Entry storage is not cleared and is read only once written.
module bounded_unsorted_list_core #(
    parameter int MAX_ENTRIES = 64,
    parameter int ITEM_WIDTH  = 32,
    localparam int CW         = $clog2(MAX_ENTRIES + 1)
) (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          in_valid,
    output logic          in_ready,
    input  logic [2:0]    operation,
    input  logic [31:0]   value,
    output logic          out_valid,
    input  logic          out_ready,
    output logic [1:0]    status,
    output logic          found,
    output logic [31:0]   item_out,
    output logic          has_next,
    output logic [CW-1:0] entry_count,
    output logic          is_empty,
    output logic          is_full
);

    localparam int EW = (ITEM_WIDTH < 32) ? ITEM_WIDTH : 32;
    localparam logic [CW-1:0] MaxCount = CW'(MAX_ENTRIES);

    buc_pkg::state_t  state_reg, state_next;
    logic [2:0]       op_reg;
    logic [EW-1:0]    val_reg;
    logic [CW-1:0]    count_reg, count_next;
    logic [CW-1:0]    cursor_reg, cursor_next;
    logic             ended_reg, ended_next;

    logic             out_valid_reg, out_valid_next;
    logic [1:0]       status_reg, status_next;
    logic             found_reg, found_next;
    logic [31:0]      item_reg, item_next;

    logic             accept;
    logic             commit;
    logic             any_match;
    logic             any_before;
    logic [EW-1:0]    rd_data;
    logic [CW-1:0]    cur_adj;
    logic [CW-1:0]    cnt_dec;

    buc_pkg::cell_cmd_t  cmd;
    buc_pkg::cell_stat_t cell_stat [MAX_ENTRIES];
    logic [EW-1:0]       cell_data [MAX_ENTRIES];
    logic [EW-1:0]       cell_rd   [MAX_ENTRIES];
    logic [MAX_ENTRIES:0] prefix;

    // Handshake
    assign in_ready = (state_reg == buc_pkg::S_IDLE);
    assign accept   = in_valid && in_ready;
    assign commit   = (state_reg == buc_pkg::S_COMMIT) && (!out_valid_reg || out_ready);

    // Word capture
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            op_reg  <= operation;
            val_reg <= value[EW-1:0];
        end
    end

    // Cell commands
    always_comb
    begin
        cmd.match_en = accept;
        cmd.ins_en   = commit && (op_reg == buc_pkg::OP_INSERT) && (count_reg < MaxCount);
        cmd.del_en   = commit && (op_reg == buc_pkg::OP_DELETE) && any_match;
    end

    // Chain of cells; compare uses the incoming value during accept
    assign prefix[0] = 1'b0;
    generate
        for (genvar gi = 0; gi < MAX_ENTRIES; gi++)
        begin : g_cell
            logic [EW-1:0] right_d;
            if (gi == MAX_ENTRIES - 1)
            begin : g_last
                assign right_d = '0;
            end
            else
            begin : g_mid
                assign right_d = cell_data[gi + 1];
            end
            buc_cell #(
                .EW       (EW),
                .CW       (CW),
                .CELL_IDX (gi)
            ) u_cell (
                .clk        (clk),
                .cmd        (cmd),
                .cmp_value  (accept ? value[EW-1:0] : val_reg),
                .count      (count_reg),
                .cursor     (cursor_reg),
                .right_data (right_d),
                .prefix_in  (prefix[gi]),
                .prefix_out (prefix[gi + 1]),
                .data_out   (cell_data[gi]),
                .rd_out     (cell_rd[gi]),
                .stat       (cell_stat[gi])
            );
        end
    endgenerate

    // Collect match flags and the cursor tap from the cells
    always_comb
    begin
        any_before = 1'b0;
        rd_data    = '0;
        for (int i = 0; i < MAX_ENTRIES; i++)
        begin
            any_before = any_before | cell_stat[i].before_cur;
            rd_data    = rd_data | cell_rd[i];
        end
    end
    assign any_match = prefix[MAX_ENTRIES];

    assign cnt_dec = count_reg - CW'(1);
    assign cur_adj = any_before ? (cursor_reg - CW'(1)) : cursor_reg;

    // Sequencer and list state update
    always_comb
    begin
        state_next     = state_reg;
        count_next     = count_reg;
        cursor_next    = cursor_reg;
        ended_next     = ended_reg;
        out_valid_next = out_valid_reg && !out_ready;
        status_next    = status_reg;
        found_next     = found_reg;
        item_next      = item_reg;
        case (state_reg)
            buc_pkg::S_IDLE:
            begin
                if (accept)
                begin
                    state_next = buc_pkg::S_COMMIT;
                end
            end
            buc_pkg::S_COMMIT:
            begin
                if (commit)
                begin
                    state_next     = buc_pkg::S_IDLE;
                    out_valid_next = 1'b1;
                    status_next    = buc_pkg::ST_OK;
                    found_next     = 1'b0;
                    item_next      = '0;
                    case (op_reg)
                        buc_pkg::OP_INSERT:
                        begin
                            if (count_reg >= MaxCount)
                            begin
                                status_next = buc_pkg::ST_FULL;
                            end
                            else
                            begin
                                count_next = count_reg + CW'(1);
                            end
                        end
                        buc_pkg::OP_DELETE:
                        begin
                            if (!any_match)
                            begin
                                status_next = buc_pkg::ST_NOTFOUND;
                            end
                            else
                            begin
                                found_next = 1'b1;
                                count_next = cnt_dec;
                                if (!ended_reg)
                                begin
                                    cursor_next = cur_adj;
                                    if (cur_adj >= cnt_dec)
                                    begin
                                        ended_next = 1'b1;
                                    end
                                end
                            end
                        end
                        buc_pkg::OP_LOOKUP:
                        begin
                            if (!any_match)
                            begin
                                status_next = buc_pkg::ST_NOTFOUND;
                            end
                            else
                            begin
                                found_next = 1'b1;
                            end
                        end
                        buc_pkg::OP_RST_CUR:
                        begin
                            cursor_next = '0;
                            ended_next  = (count_reg == '0);
                        end
                        buc_pkg::OP_READ_NEXT:
                        begin
                            if (ended_reg || (cursor_reg >= count_reg))
                            begin
                                ended_next  = 1'b1;
                                status_next = buc_pkg::ST_NO_NEXT;
                            end
                            else
                            begin
                                item_next   = 32'(rd_data);
                                cursor_next = cursor_reg + CW'(1);
                                if ((cursor_reg + CW'(1)) >= count_reg)
                                begin
                                    ended_next = 1'b1;
                                end
                            end
                        end
                        default:
                        begin
                        end
                    endcase
                end
            end
            default:
            begin
                state_next = buc_pkg::S_IDLE;
            end
        endcase
    end

    // Control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= buc_pkg::S_IDLE;
            count_reg     <= '0;
            cursor_reg    <= '0;
            ended_reg     <= 1'b1;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            count_reg     <= count_next;
            cursor_reg    <= cursor_next;
            ended_reg     <= ended_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // Result payload
    always_ff @(posedge clk)
    begin
        status_reg <= status_next;
        found_reg  <= found_next;
        item_reg   <= item_next;
    end

    // Outputs; flags track the state left by the last committed word
    assign out_valid   = out_valid_reg;
    assign status      = status_reg;
    assign found       = found_reg;
    assign item_out    = item_reg;
    assign has_next    = !ended_reg;
    assign entry_count = count_reg;
    assign is_empty    = (count_reg == '0);
    assign is_full     = (count_reg >= MaxCount);

    // Commit with a free output slot always returns to idle
    a_commit_done: assert property (@(posedge clk) disable iff (!rst_n)
        commit |=> (state_reg == buc_pkg::S_IDLE) && out_valid_reg)
        else $error("commit did not deliver a result");

    // An insert with room grows the count by exactly one
    a_insert_grows: assert property (@(posedge clk) disable iff (!rst_n)
        (commit && (op_reg == buc_pkg::OP_INSERT) && (count_reg < MaxCount))
        |=> (count_reg == $past(count_reg) + CW'(1)))
        else $error("insert did not grow count");

    // A live cursor always points at a held entry
    a_cursor_live: assert property (@(posedge clk) disable iff (!rst_n)
        !ended_reg |-> (cursor_reg < count_reg))
        else $error("live cursor past end of list");

    // Count never exceeds capacity
    a_count_cap: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= MaxCount)
        else $error("count above capacity");

endmodule
